/* design/tsdq_pkg.sv */
package tsdq_pkg;

   localparam int DefaultDepth = 32;
   localparam int TimeWidth    = 62;
   localparam int TagWidth     = 32;
   localparam int EdgeWidth    = 64;
   localparam int EntryWidth   = TimeWidth + TagWidth;
   localparam int ReqDataWidth = 160;
   localparam int RspDataWidth = 96;

   typedef enum logic [1:0] {
      KIND_EDGE   = 2'd0,
      KIND_NOTIME = 2'd1,
      KIND_FULL   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_REL_RD,
      ST_REL_CHK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [TagWidth-1:0]  tag;
      logic [TimeWidth-1:0] tstamp;
      kind_type             kind;
   } result_type;

endpackage

/* design/tsdq_ram.sv */
module tsdq_ram #(
   parameter int Depth = tsdq_pkg::DefaultDepth,
   parameter int Width = tsdq_pkg::EntryWidth
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/timestamp_sorted_delay_queue.sv */
// Timestamp reorder buffer. Items are held in one RAM used as a circular,
// sorted store of QUEUE_DEPTH entries. An item without a timestamp is
// passed straight to the output. A stored item is walked into place past
// each entry with a later timestamp, one RAM read and one write-back per
// shift, then due entries are released; an item that finds the store full
// is not stored and is returned with the full kind. The RAM read is
// registered, so the walk splits each step into a read and a compare state.
// Results leave through an output register, so a stalled rsp side holds the sequencer.
module timestamp_sorted_delay_queue #(
   parameter int QUEUE_DEPTH = tsdq_pkg::DefaultDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [tsdq_pkg::TimeWidth-1:0]    csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // item_time, edge_time, item_tag, zero pad
   input  logic [tsdq_pkg::ReqDataWidth-1:0] req_tdata,
   // has_time, has_edge
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_tag, out_time, zero pad
   output logic [tsdq_pkg::RspDataWidth-1:0] rsp_tdata,
   // release_kind
   output logic [1:0]                        rsp_tuser,
   // last_of_run
   output logic                              rsp_tlast
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = tsdq_pkg::TimeWidth;
   localparam int GW = tsdq_pkg::TagWidth;
   localparam int EW = tsdq_pkg::EdgeWidth;

   tsdq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [EW-1:0] edge_ff, edge_in;
   logic [TW-1:0] lag_ff;
   logic [TW-1:0] t_ff, t_in;
   logic [GW-1:0] tag_ff, tag_in;
   logic pend_v_ff, pend_v_in;
   tsdq_pkg::result_type pend_ff, pend_in;
   logic out_v_ff, out_v_in, out_last_ff, out_last_in;
   tsdq_pkg::result_type out_ff, out_in;

   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [tsdq_pkg::EntryWidth-1:0] wr_data, rd_data;
   logic [TW-1:0] rd_time;
   logic [GW-1:0] rd_tag;
   logic out_free, due;
   logic [AW:0] sum_a;

   tsdq_ram #(.Depth(QUEUE_DEPTH), .Width(tsdq_pkg::EntryWidth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time  = rd_data[TW-1:0];
   assign rd_tag   = rd_data[TW+GW-1:TW];
   assign out_free = !out_v_ff || rsp_tready;
   assign due      = !edge_ff[EW-1] && ({1'b0, rd_time} <= edge_ff[EW-2:0]);

   function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= (AW+1)'(QUEUE_DEPTH)) ? s - (AW+1)'(QUEUE_DEPTH) : s;
      return r[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tsdq_pkg::ST_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         edge_ff   <= '0;
         lag_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         edge_ff   <= edge_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         if (csr_wr_en) begin
            lag_ff <= csr_wr_data;
         end
      end
      idx_ff      <= idx_in;
      t_ff        <= t_in;
      tag_ff      <= tag_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      idx_in      = idx_ff;
      edge_in     = edge_ff;
      t_in        = t_ff;
      tag_in      = tag_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      wr_en       = 1'b0;
      wr_data     = {tag_ff, t_ff};
      sum_a       = (AW+1)'(head_ff) + (AW+1)'(idx_ff);
      wr_addr     = wrap(sum_a);
      rd_en       = 1'b0;
      rd_addr     = wrap(sum_a - (AW+1)'(1));
      req_tready  = (state_ff == tsdq_pkg::ST_IDLE);
      unique case (state_ff)
         tsdq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               t_in   = req_tdata[TW-1:0];
               tag_in = req_tdata[2*TW+GW-1:2*TW];
               idx_in = count_ff;
               if (!req_tuser[0]) begin
                  pend_v_in = 1'b1;
                  pend_in   = '{tag: req_tdata[2*TW+GW-1:2*TW], tstamp: '0,
                                kind: tsdq_pkg::KIND_NOTIME};
                  state_in  = tsdq_pkg::ST_FLUSH;
               end else begin
                  if (req_tuser[1]) begin
                     edge_in = EW'(req_tdata[2*TW-1:TW]) - EW'(lag_ff);
                  end
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     pend_v_in = 1'b1;
                     pend_in   = '{tag: req_tdata[2*TW+GW-1:2*TW],
                                   tstamp: req_tdata[TW-1:0],
                                   kind: tsdq_pkg::KIND_FULL};
                     state_in  = tsdq_pkg::ST_REL_RD;
                  end else begin
                     state_in = tsdq_pkg::ST_INS_RD;
                  end
               end
            end
         end
         tsdq_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = tsdq_pkg::ST_REL_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = tsdq_pkg::ST_INS_CHK;
            end
         end
         tsdq_pkg::ST_INS_CHK: begin
            wr_en = 1'b1;
            if (rd_time > t_ff) begin
               wr_data  = rd_data;
               idx_in   = idx_ff - CW'(1);
               state_in = tsdq_pkg::ST_INS_RD;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = tsdq_pkg::ST_REL_RD;
            end
         end
         tsdq_pkg::ST_REL_RD: begin
            rd_addr = head_ff;
            if (count_ff == '0 || edge_ff[EW-1]) begin
               state_in = tsdq_pkg::ST_FLUSH;
            end else begin
               rd_en    = 1'b1;
               state_in = tsdq_pkg::ST_REL_CHK;
            end
         end
         tsdq_pkg::ST_REL_CHK: begin
            if (!due) begin
               state_in = tsdq_pkg::ST_FLUSH;
            end else if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_in      = pend_ff;
                  out_last_in = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_in   = '{tag: rd_tag, tstamp: rd_time, kind: tsdq_pkg::KIND_EDGE};
               head_in   = wrap((AW+1)'(head_ff) + (AW+1)'(1));
               count_in  = count_ff - CW'(1);
               state_in  = tsdq_pkg::ST_REL_RD;
            end
         end
         tsdq_pkg::ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = tsdq_pkg::ST_IDLE;
            end else if (out_free) begin
               out_v_in    = 1'b1;
               out_in      = pend_ff;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
               state_in    = tsdq_pkg::ST_IDLE;
            end
         end
         default: state_in = tsdq_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_ff.tstamp, out_ff.tag};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above depth");

   a_pend_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsdq_pkg::ST_IDLE |-> !pend_v_ff)
      else $error("pending result left at idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsdq_pkg::ST_INS_CHK && rd_time <= t_ff |=> count_ff != '0)
      else $error("insert did not grow store");

endmodule
